[design/ebp_pkg.sv]
// ----------------------------------------------------------------------------
// ebp_pkg
// Shared types and constants of the EDID base block parser.
// ----------------------------------------------------------------------------
package ebp_pkg;

	localparam int DESC_COUNT_DEF = 4;
	localparam int DESC_BASE      = 54;
	localparam int DESC_LEN       = 18;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [2:0] KIND_BASIC = 3'd0;
	localparam logic [2:0] KIND_STD   = 3'd1;
	localparam logic [2:0] KIND_DTD   = 3'd2;
	localparam logic [2:0] KIND_NAME  = 3'd3;
	localparam logic [2:0] KIND_END   = 3'd4;

	localparam logic [32:0] ST_COMPLETE  = 33'd0;
	localparam logic [32:0] ST_BAD_HDR   = 33'd1;
	localparam logic [32:0] ST_BAD_DEPTH = 33'd2;
	localparam logic [32:0] ST_ANALOG    = 33'd3;

	localparam logic [7:0] NAME_TAG   = 8'hFC;
	localparam logic [7:0] STD_UNUSED = 8'h01;

	typedef struct packed {
		logic [2:0]  kind;
		logic [11:0] h_active;
		logic [11:0] v_active;
		logic [15:0] dot_clock;
		logic [6:0]  refresh_hz;
		logic [11:0] h_blank;
		logic [11:0] v_blank;
		logic [33:0] sync_word;
		logic [39:0] size_word;
		logic [32:0] info_word;
		logic        last;
	} rec_t;

	typedef struct packed {
		logic [1:0] count;
		logic       full;
	} qstat_t;

	function automatic logic [7:0] header_byte(input logic [2:0] idx);
		header_byte = (idx == 3'd0 || idx == 3'd7) ? 8'h00 : 8'hff;
	endfunction

	function automatic logic [11:0] depth_bits(input logic [2:0] code);
		case (code)
			3'd1: depth_bits = 12'd6;
			3'd2: depth_bits = 12'd8;
			3'd3: depth_bits = 12'd10;
			3'd4: depth_bits = 12'd12;
			3'd5: depth_bits = 12'd14;
			3'd6: depth_bits = 12'd16;
			default: depth_bits = 12'd0;
		endcase
	endfunction

endpackage

[design/ebp_front.sv]
// ----------------------------------------------------------------------------
// ebp_front
// Tracks the byte position, holds block state and forms at most one record per byte.
// ----------------------------------------------------------------------------
module ebp_front #(
	parameter int DESCRIPTOR_COUNT = ebp_pkg::DESC_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic [7:0]    data_byte,
	input  logic          block_start,
	output logic          push,
	output ebp_pkg::rec_t rec
);
	import ebp_pkg::*;

	localparam logic [6:0] DESC_END = 7'(DESC_BASE + DESC_LEN * DESCRIPTOR_COUNT);
	localparam logic [6:0] P_DESC   = 7'(DESC_BASE);

	logic [6:0]  pos_q;
	logic        failed_q;
	logic [7:0]  input_q;
	logic [15:0] est_low_q;
	logic [7:0]  gamma_q;
	logic [7:0]  std_first_q;
	logic [7:0]  desc_q [17];

	logic [6:0]  p;
	logic        active;
	logic [6:0]  d;
	logic [4:0]  off;
	logic        display;
	logic        emit;
	logic        fin;
	logic        vpol, hpol;
	logic [11:0] h_std;

	assign p      = block_start ? 7'd0 : pos_q;
	assign active = !(block_start ? 1'b0 : failed_q);
	assign d      = p - P_DESC;

	always_comb begin
		off = 5'(d);
		for (int k = 1; k < DESCRIPTOR_COUNT; k++) begin
			if (d >= 7'(DESC_LEN * k)) off = 5'(d - 7'(DESC_LEN * k));
		end
	end

	// Bytes 0 and 1 of the current descriptor are already stored by offset 5.
	assign display = desc_q[0] == 8'h00 && desc_q[1] == 8'h00;
	assign vpol    = data_byte[2];
	assign hpol    = data_byte[3] ? data_byte[1] : vpol;
	assign h_std   = 12'({4'd0, std_first_q} + 12'd31) << 3;

	always_comb begin
		rec  = '0;
		emit = 1'b0;
		fin  = 1'b0;
		if (p < 7'd8) begin
			if (data_byte != header_byte(p[2:0])) begin
				fin = 1'b1;
				rec.info_word = ST_BAD_HDR;
			end
		end else if (p == 7'd20) begin
			if (data_byte[7] && data_byte[6:4] == 3'd7) begin
				fin = 1'b1;
				rec.info_word = ST_BAD_DEPTH;
			end
		end else if (p == 7'd37) begin
			emit = 1'b1;
			rec.kind = KIND_BASIC;
			if (input_q[7]) begin
				rec.h_active = depth_bits(input_q[6:4]);
				rec.v_active = {8'd0, input_q[3:0]};
			end
			rec.info_word = {data_byte, est_low_q, gamma_q, input_q[7]};
		end else if (p >= 7'd38 && p < P_DESC) begin
			if (p[0] && !(std_first_q == STD_UNUSED && data_byte == STD_UNUSED)) begin
				emit = 1'b1;
				rec.kind       = KIND_STD;
				rec.h_active   = h_std;
				rec.refresh_hz = {2'd0, data_byte[4:0]} + 7'd60;
				rec.info_word  = {31'd0, data_byte[7:6]};
			end
		end else if (p >= P_DESC && p < DESC_END) begin
			if (off >= 5'd5 && display && desc_q[3] == NAME_TAG) begin
				emit = 1'b1;
				rec.kind      = KIND_NAME;
				rec.info_word = {25'd0, data_byte};
			end else if (off == 5'd17 && !display) begin
				if (!data_byte[4]) begin
					fin = 1'b1;
					rec.info_word = ST_ANALOG;
				end else begin
					emit = 1'b1;
					rec.kind        = KIND_DTD;
					rec.dot_clock   = {desc_q[1], desc_q[0]};
					rec.h_active    = {desc_q[4][7:4], desc_q[2]};
					rec.h_blank     = {desc_q[4][3:0], desc_q[3]};
					rec.v_active    = {desc_q[7][7:4], desc_q[5]};
					rec.v_blank     = {desc_q[7][3:0], desc_q[6]};
					rec.sync_word   = {desc_q[11][7:6], desc_q[8], desc_q[11][5:4], desc_q[9],
						desc_q[11][3:2], desc_q[10][7:4], desc_q[11][1:0], desc_q[10][3:0],
						hpol, vpol};
					rec.size_word   = {desc_q[14][7:4], desc_q[12], desc_q[14][3:0], desc_q[13],
						desc_q[15], desc_q[16]};
				end
			end
		end else if (p == 7'd127) begin
			fin = 1'b1;
			rec.info_word = ST_COMPLETE;
		end
		if (fin) begin
			emit     = 1'b1;
			rec.kind = KIND_END;
			rec.last = 1'b1;
		end
	end

	assign push = take && active && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			failed_q    <= 1'b0;
			input_q     <= '0;
			est_low_q   <= '0;
			gamma_q     <= '0;
			std_first_q <= '0;
		end else if (take) begin
			// A start mark always makes the byte active, so this also rewrites the flag from this byte.
			if (active) begin
				pos_q    <= p + 7'd1;
				failed_q <= fin;
				if (p == 7'd20) input_q <= data_byte;
				if (p == 7'd23) gamma_q <= data_byte;
				if (p == 7'd35) est_low_q[7:0] <= data_byte;
				if (p == 7'd36) est_low_q[15:8] <= data_byte;
				if (p >= 7'd38 && p < P_DESC && !p[0]) std_first_q <= data_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && active && p >= P_DESC && p < DESC_END && off < 5'd17)
			desc_q[off] <= data_byte;
	end

endmodule

[design/ebp_queue.sv]
// ----------------------------------------------------------------------------
// ebp_queue
// Two-entry record queue between the front and the back.
// ----------------------------------------------------------------------------
module ebp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ebp_pkg::rec_t  wr_rec,
	input  logic           pop,
	output logic           not_empty,
	output ebp_pkg::rec_t  rd_rec,
	output ebp_pkg::qstat_t stat
);
	import ebp_pkg::*;

	rec_t       mem_q [QUEUE_DEPTH];
	logic       wr_q, rd_q;
	logic [1:0] count_q;

	assign not_empty = count_q != 2'd0;
	assign rd_rec    = mem_q[rd_q];
	assign stat.count = count_q;
	assign stat.full  = count_q == 2'(QUEUE_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wr_rec;
	end

endmodule

[design/ebp_back.sv]
// ----------------------------------------------------------------------------
// ebp_back
// Finishes records (standard timing height) into the output register.
// ----------------------------------------------------------------------------
module ebp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          have,
	input  ebp_pkg::rec_t head,
	output logic          pop,
	input  logic          stall,
	output logic          valid,
	output ebp_pkg::rec_t out_rec
);
	import ebp_pkg::*;

	localparam logic [15:0] RECIP5 = 16'd52429;

	logic        valid_q;
	rec_t        out_q;
	rec_t        fin;
	logic [13:0] x4;
	logic [29:0] prod;
	logic [15:0] h5, h3, h9;

	assign x4   = {head.h_active, 2'b00};
	assign prod = 30'(x4) * 30'(RECIP5);
	assign h5   = 16'(head.h_active) * 16'd5;
	assign h3   = 16'(head.h_active) * 16'd3;
	assign h9   = 16'(head.h_active) * 16'd9;

	always_comb begin
		fin = head;
		if (head.kind == KIND_STD) begin
			case (head.info_word[1:0])
				2'd0: fin.v_active = h5[14:3];
				2'd1: fin.v_active = h3[13:2];
				2'd2: fin.v_active = prod[29:18];
				default: fin.v_active = h9[15:4];
			endcase
		end
	end

	assign pop     = have && (!valid_q || !stall);
	assign valid   = valid_q;
	assign out_rec = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (!valid_q || !stall) valid_q <= have;
	end

	always_ff @(posedge clk) begin
		if (pop) out_q <= fin;
	end

endmodule

[design/edid_block_parser_unit.sv]
// ----------------------------------------------------------------------------
// edid_block_parser_unit
// Top level of the EDID base block parser.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the two-entry record queue has room; each
// byte yields at most one record, which passes through the queue and then the
// output register. The front decodes combinationally and the back finishes a
// record as it loads that register: one byte per cycle while out_stall is low.
module edid_block_parser_unit #(
	parameter int DESCRIPTOR_COUNT = ebp_pkg::DESC_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        block_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  record_kind,
	output logic [11:0] h_active,
	output logic [11:0] v_active,
	output logic [15:0] dot_clock,
	output logic [6:0]  refresh_hz,
	output logic [11:0] h_blank,
	output logic [11:0] v_blank,
	output logic [33:0] sync_word,
	output logic [39:0] size_word,
	output logic [32:0] info_word,
	output logic        last
);
	import ebp_pkg::*;

	logic   take, push, pop, have;
	rec_t   f_rec, q_rec, o_rec;
	qstat_t q_stat;

	assign in_stall = q_stat.full;
	assign take     = in_valid && !in_stall;

	ebp_front #(.DESCRIPTOR_COUNT(DESCRIPTOR_COUNT)) u_front (
		.clk, .arst_n, .take, .data_byte, .block_start, .push, .rec(f_rec)
	);

	ebp_queue u_queue (
		.clk, .arst_n, .push, .wr_rec(f_rec), .pop, .not_empty(have),
		.rd_rec(q_rec), .stat(q_stat)
	);

	ebp_back u_back (
		.clk, .arst_n, .have, .head(q_rec), .pop, .stall(out_stall),
		.valid(out_valid), .out_rec(o_rec)
	);

	assign record_kind = o_rec.kind;
	assign h_active    = o_rec.h_active;
	assign v_active    = o_rec.v_active;
	assign dot_clock   = o_rec.dot_clock;
	assign refresh_hz  = o_rec.refresh_hz;
	assign h_blank     = o_rec.h_blank;
	assign v_blank     = o_rec.v_blank;
	assign sync_word   = o_rec.sync_word;
	assign size_word   = o_rec.size_word;
	assign info_word   = o_rec.info_word;
	assign last        = o_rec.last;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= 2'(QUEUE_DEPTH)) else $error("record queue overflow");
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (record_kind == KIND_END))) else $error("last flag mismatch");
	a_pop_have: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> have) else $error("pop from empty queue");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(have && !out_valid) |=> out_valid) else $error("back stage did not load");
`endif

endmodule

[tb/edid_block_parser_unit_test.sv]
// ----------------------------------------------------------------------------
// edid_block_parser_unit_test
// Streams EDID base blocks into the parser and checks every decoded record.
// ----------------------------------------------------------------------------
// A predictor in this file tracks the byte position and decodes each byte it
// sends into the record that the parser should produce. Each record that
// leaves the parser is compared field by field with the oldest expected one.
// Both sides idle at random: the sender works in bursts with gaps between
// them, and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module edid_block_parser_unit_test;
	import ebp_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        block_start;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  record_kind;
	logic [11:0] h_active;
	logic [11:0] v_active;
	logic [15:0] dot_clock;
	logic [6:0]  refresh_hz;
	logic [11:0] h_blank;
	logic [11:0] v_blank;
	logic [33:0] sync_word;
	logic [39:0] size_word;
	logic [32:0] info_word;
	logic        last;

	edid_block_parser_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .block_start(block_start),
		.out_valid(out_valid), .out_stall(out_stall),
		.record_kind(record_kind), .h_active(h_active), .v_active(v_active),
		.dot_clock(dot_clock), .refresh_hz(refresh_hz),
		.h_blank(h_blank), .v_blank(v_blank), .sync_word(sync_word),
		.size_word(size_word), .info_word(info_word), .last(last)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Predictor state.
	logic [6:0] pos_q;
	logic       ended_q;
	logic [7:0] input_def_q;
	logic [15:0] est_low_q;
	logic [7:0] gamma_q;
	logic [7:0] std_first_q;
	logic [7:0] desc_q [0:16];

	rec_t record_q [$];
	int   error_count;
	int   record_count;
	int   byte_count;
	int   cycle_count;
	int   burst_left;
	int   stall_mode;

	task automatic report_mismatch(input string what, input logic [39:0] got,
		input logic [39:0] want);
		$display("MISMATCH %s: got %0h, expected %0h (record %0d)", what, got, want,
			record_count);
		error_count++;
	endtask

	function automatic rec_t end_record(input logic [32:0] status);
		rec_t r;
		r = '0;
		r.kind = KIND_END;
		r.info_word = status;
		r.last = 1'b1;
		ended_q = 1'b1;
		return r;
	endfunction

	function automatic logic [11:0] expect_depth(input logic [2:0] code);
		logic [11:0] d;
		d = (code == 3'd0 || code == 3'd7) ? 12'd0 : 12'd4 + 12'd2 * code;
		return d;
	endfunction

	// Decodes one byte; returns 1 with the record when the byte yields one.
	function automatic bit decode_byte(input logic [7:0] b, input logic start,
		output rec_t r);
		int p;
		int off;
		int h;
		int num;
		int den;
		bit dsp;
		logic vpol;
		logic hpol;
		r = '0;
		if (start) begin
			pos_q = '0;
			ended_q = 1'b0;
		end
		if (ended_q)
			return 0;
		p = pos_q;
		pos_q = pos_q + 7'd1;
		if (p < 8) begin
			if (b != (((p == 0) || (p == 7)) ? 8'h00 : 8'hff)) begin
				r = end_record(ST_BAD_HDR);
				return 1;
			end
			return 0;
		end
		if (p == 20) begin
			input_def_q = b;
			if (b[7] && b[6:4] == 3'd7) begin
				r = end_record(ST_BAD_DEPTH);
				return 1;
			end
			return 0;
		end
		if (p == 23) begin
			gamma_q = b;
			return 0;
		end
		if (p == 35) begin
			est_low_q = {8'h00, b};
			return 0;
		end
		if (p == 36) begin
			est_low_q[15:8] = b;
			return 0;
		end
		if (p == 37) begin
			r.kind = KIND_BASIC;
			if (input_def_q[7]) begin
				r.h_active = expect_depth(input_def_q[6:4]);
				r.v_active = {8'h00, input_def_q[3:0]};
			end
			r.info_word = {b, est_low_q, gamma_q, input_def_q[7]};
			return 1;
		end
		if (p >= 38 && p < 54) begin
			if (p % 2 == 0) begin
				std_first_q = b;
				return 0;
			end
			if (std_first_q == STD_UNUSED && b == STD_UNUSED)
				return 0;
			case (b[7:6])
				2'd0: begin num = 16; den = 10; end
				2'd1: begin num = 4; den = 3; end
				2'd2: begin num = 5; den = 4; end
				default: begin num = 16; den = 9; end
			endcase
			h = (std_first_q + 31) * 8;
			r.kind = KIND_STD;
			r.h_active = 12'(h);
			r.v_active = 12'((h * den) / num);
			r.refresh_hz = b[4:0] + 7'd60;
			r.info_word = {31'd0, b[7:6]};
			return 1;
		end
		if (p >= DESC_BASE && p < DESC_BASE + DESC_LEN * 4) begin
			off = (p - DESC_BASE) % DESC_LEN;
			// The display flag is taken before this byte is stored.
			dsp = (desc_q[0] == 8'h00 && desc_q[1] == 8'h00);
			if (off < 17)
				desc_q[off] = b;
			if (off >= 5 && dsp && desc_q[3] == NAME_TAG) begin
				r.kind = KIND_NAME;
				r.info_word = {25'd0, b};
				return 1;
			end
			if (off == 17 && !dsp) begin
				if (!b[4]) begin
					r = end_record(ST_ANALOG);
					return 1;
				end
				vpol = b[2];
				hpol = b[3] ? b[1] : vpol;
				r.kind = KIND_DTD;
				r.dot_clock = {desc_q[1], desc_q[0]};
				r.h_active = {desc_q[4][7:4], desc_q[2]};
				r.h_blank = {desc_q[4][3:0], desc_q[3]};
				r.v_active = {desc_q[7][7:4], desc_q[5]};
				r.v_blank = {desc_q[7][3:0], desc_q[6]};
				r.sync_word = {desc_q[11][7:6], desc_q[8], desc_q[11][5:4], desc_q[9],
					desc_q[11][3:2], desc_q[10][7:4], desc_q[11][1:0], desc_q[10][3:0],
					hpol, vpol};
				r.size_word = {desc_q[14][7:4], desc_q[12], desc_q[14][3:0], desc_q[13],
					desc_q[15], desc_q[16]};
				return 1;
			end
			return 0;
		end
		if (p == 127) begin
			r = end_record(ST_COMPLETE);
			return 1;
		end
		return 0;
	endfunction

	// Valid stays high after an accepted item; the next call or a drain decides
	// what happens in the following cycle.
	task automatic send_byte(input logic [7:0] b, input logic start);
		rec_t r;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		block_start <= start;
		do
			@(posedge clk);
		while (in_stall);
		if (decode_byte(b, start, r))
			record_q.push_back(r);
		byte_count++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (record_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Builds a well-formed block; mode picks which fault, if any, it carries.
	task automatic send_block(input int mode);
		logic [7:0] blk [0:127];
		int d;
		int k;
		for (int i = 0; i < 128; i++)
			blk[i] = 8'($urandom_range(0, 255));
		for (int i = 0; i < 8; i++)
			blk[i] = (i == 0 || i == 7) ? 8'h00 : 8'hff;
		if (blk[20][7] && blk[20][6:4] == 3'd7)
			blk[20][6:4] = 3'($urandom_range(0, 6));
		for (int i = 38; i < 54; i += 2)
			if ($urandom_range(0, 3) == 0) begin
				blk[i] = STD_UNUSED;
				blk[i + 1] = STD_UNUSED;
			end
		for (d = 0; d < 4; d++) begin
			k = DESC_BASE + d * DESC_LEN;
			case ($urandom_range(0, 3))
				0: begin
					blk[k] = 8'h00;
					blk[k + 1] = 8'h00;
					blk[k + 3] = NAME_TAG;
				end
				1: begin
					blk[k] = 8'h00;
					blk[k + 1] = 8'h00;
				end
				default: begin
					if (blk[k] == 8'h00 && blk[k + 1] == 8'h00)
						blk[k] = 8'h01;
					blk[k + 17][4] = 1'b1;
				end
			endcase
		end
		case (mode)
			1: blk[$urandom_range(0, 7)] ^= 8'h01 << $urandom_range(0, 7);
			2: begin
				blk[20][7] = 1'b1;
				blk[20][6:4] = 3'd7;
			end
			3: begin
				k = DESC_BASE + $urandom_range(0, 3) * DESC_LEN;
				blk[k] = 8'h12;
				blk[k + 17][4] = 1'b0;
			end
			default: ;
		endcase
		for (int i = 0; i < 128; i++)
			send_byte(blk[i], i == 0);
		// Bytes after the end are ignored; a few are sent to show that.
		if ($urandom_range(0, 1))
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic test_directed();
		logic [7:0] b;
		// No start mark after reset: the first byte counts as byte 0.
		for (int i = 0; i < 8; i++)
			send_byte((i == 0 || i == 7) ? 8'h00 : 8'hff, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h55, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		for (int i = 0; i < 10; i++) begin
			b = 8'($urandom_range(0, 255));
			send_byte(b, 1'b0);
		end
		wait_drained();
	endtask

	task automatic test_faults();
		send_block(1);
		send_block(2);
		send_block(3);
		wait_drained();
	endtask

	task automatic test_random();
		while (byte_count < 900) begin
			case ($urandom_range(0, 9))
				0: send_block($urandom_range(1, 3));
				1: repeat ($urandom_range(1, 20))
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
				default: send_block(0);
			endcase
			if ($urandom_range(0, 5) == 0)
				wait_drained();
		end
	endtask

	task automatic test_extremes();
		logic [7:0] blk [0:127];
		for (int v = 0; v < 2; v++) begin
			for (int i = 0; i < 128; i++)
				blk[i] = v ? 8'hff : 8'h00;
			for (int i = 0; i < 8; i++)
				blk[i] = (i == 0 || i == 7) ? 8'h00 : 8'hff;
			blk[20] = v ? 8'hef : 8'h80;
			blk[54 + 17] = v ? 8'hf7 : 8'h10;
			blk[54] = 8'h01;
			for (int i = 0; i < 128; i++)
				send_byte(blk[i], i == 0);
		end
		wait_drained();
	endtask

	// Receiver: stall pattern changes now and then between modes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode <= 0;
		end else begin
			if ($urandom_range(0, 99) == 0)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 1) == 0);
				default: out_stall <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		rec_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (record_q.size() == 0) begin
				report_mismatch("unexpected record kind", 40'(record_kind), 40'd0);
			end else begin
				w = record_q.pop_front();
				if (record_kind !== w.kind) report_mismatch("kind", record_kind, w.kind);
				if (h_active !== w.h_active) report_mismatch("h_active", h_active, w.h_active);
				if (v_active !== w.v_active) report_mismatch("v_active", v_active, w.v_active);
				if (dot_clock !== w.dot_clock)
					report_mismatch("dot_clock", dot_clock, w.dot_clock);
				if (refresh_hz !== w.refresh_hz)
					report_mismatch("refresh_hz", refresh_hz, w.refresh_hz);
				if (h_blank !== w.h_blank) report_mismatch("h_blank", h_blank, w.h_blank);
				if (v_blank !== w.v_blank) report_mismatch("v_blank", v_blank, w.v_blank);
				if (sync_word !== w.sync_word)
					report_mismatch("sync_word", sync_word, w.sync_word);
				if (size_word !== w.size_word)
					report_mismatch("size_word", size_word, w.size_word);
				if (info_word !== w.info_word)
					report_mismatch("info_word", info_word, w.info_word);
				if (last !== w.last) report_mismatch("last", last, w.last);
			end
			record_count++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 200000) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		block_start = 1'b0;
		error_count = 0;
		record_count = 0;
		byte_count = 0;
		cycle_count = 0;
		burst_left = 0;
		pos_q = '0;
		ended_q = 1'b0;
		input_def_q = '0;
		est_low_q = '0;
		gamma_q = '0;
		std_first_q = '0;
		for (int i = 0; i < 17; i++)
			desc_q[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_extremes();
		test_faults();
		test_random();
		wait_drained();
		repeat (20) @(posedge clk);
		if (record_q.size() != 0) begin
			$display("%0d expected records never arrived", record_q.size());
			error_count++;
		end
		$display("Sent %0d bytes covering headers, faults, timings and names;", byte_count);
		$display("checked %0d records with %0d mismatches.", record_count, error_count);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
